// ----- rtl/tmm_pkg.sv -----
// Shared types and constants for the tricopter motor mixer.
// Word layouts of both stream channels, the register file and the stage-one record.
// No dependencies.
`default_nettype none

package tmm_pkg;

    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Register reset values
    localparam logic [11:0] MIN_THROTTLE_RST   = 12'd1100;
    localparam logic [11:0] PULSE_MAX_RST      = 12'd2000;
    localparam logic [11:0] PULSE_MIN_RST      = 12'd1000;
    localparam logic [11:0] PULSE_CENTRE_RST   = 12'd1500;
    localparam logic [11:0] ALT_LEVEL_RST      = 12'd1300;
    localparam logic [11:0] HEADING_LEVEL_RST  = 12'd1300;
    localparam logic [11:0] THROTTLE_ZONE_RST  = 12'd50;
    localparam logic [7:0]  HEADING_GAIN_RST   = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_THROTTLE   = 3'd0,
        CFG_PULSE_MAX      = 3'd1,
        CFG_PULSE_MIN      = 3'd2,
        CFG_PULSE_CENTRE   = 3'd3,
        CFG_ALT_LEVEL      = 3'd4,
        CFG_HEADING_LEVEL  = 3'd5,
        CFG_THROTTLE_ZONE  = 3'd6,
        CFG_HEADING_GAIN   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] min_throttle;
        logic [11:0] pulse_max;
        logic [11:0] pulse_min;
        logic [11:0] pulse_centre;
        logic [11:0] alt_switch_level;
        logic [11:0] heading_switch_level;
        logic [11:0] throttle_zone;
        logic [7:0]  heading_gain;
    } cfg_t;

    // Input word, lowest field last
    typedef struct packed {
        logic [5:0]         pad;
        logic signed [8:0]  pitch_deg;
        logic signed [8:0]  roll_deg;
        logic signed [8:0]  heading_deg;
        logic [11:0]        heading_switch;
        logic signed [10:0] yaw_stick;
        logic signed [11:0] yaw_drive;
        logic signed [11:0] roll_drive;
        logic signed [11:0] pitch_drive;
        logic signed [11:0] alt_correction;
        logic [11:0]        alt_switch;
        logic [11:0]        throttle_level;
    } in_word_t;

    // Result word, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic        alt_active;
        logic        alt_engage;
        logic [11:0] tail_servo;
        logic [11:0] motor_tail;
        logic [11:0] motor_right;
        logic [11:0] motor_left;
    } out_word_t;

    // Hold stage result handed to the mixer
    typedef struct packed {
        logic [11:0]        thr;
        logic               engage;
        logic               active;
        logic signed [11:0] pitch_drive;
        logic signed [11:0] roll_drive;
        logic signed [11:0] yaw_drive;
        logic signed [10:0] yaw_stick;
        logic signed [18:0] head_prod;
    } hold_t;

endpackage

`default_nettype wire

// ----- rtl/tricopter_motor_mixer.sv -----
// Tricopter motor mixer: one control update in, three motor pulses and a servo pulse out.
// Three register stages: input word, hold stage, result word.
// Depends on tmm_pkg, tmm_hold and tmm_mix.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one control update per word; m_tvalid/m_tready/m_tdata
//   carry one result per update. A word moves when tvalid and tready are both high.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only while no update is
//   in flight.
//   An accepted word passes through the input register, hold register and result register
//   before its result shows on m_tdata.
//   Throughput: one update per cycle while m_tready stays high, set by the combinational
//   hold and mix logic; the latch state advances as each update leaves the input register.
//   Reset clears all valids, the hold latches and the held values, and loads the register
//   defaults; the block can take a word in the first cycle after reset.
//   When the receiver stalls, the result holds and the two earlier stages keep filling;
//   s_tready falls only once all three stages are full.
`default_nettype none

module tricopter_motor_mixer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // throttle_level, alt_switch, alt_correction, pitch_drive, roll_drive, yaw_drive,
    // yaw_stick, heading_switch, heading_deg, roll_deg, pitch_deg, zero pad
    input  wire logic [tmm_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // motor_left, motor_right, motor_tail, tail_servo, alt_engage, alt_active, zero pad
    output logic [tmm_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tmm_pkg::cfg_t      cfg_reg;
    tmm_pkg::in_word_t  in_word_reg;
    tmm_pkg::hold_t     hold_word;
    tmm_pkg::hold_t     mid_word_reg;
    tmm_pkg::out_word_t mix_word;
    tmm_pkg::out_word_t out_word_reg;
    logic               in_valid_reg;
    logic               mid_valid_reg;
    logic               out_valid_reg;
    logic               out_en;
    logic               mid_en;
    logic               in_en;
    logic               hold_fire;

    // Stage enables
    assign out_en    = !out_valid_reg || m_tready;
    assign mid_en    = !mid_valid_reg || out_en;
    assign in_en     = !in_valid_reg || mid_en;
    assign hold_fire = in_valid_reg && mid_en;
    assign s_tready  = in_en;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_word_reg;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_throttle         <= tmm_pkg::MIN_THROTTLE_RST;
            cfg_reg.pulse_max            <= tmm_pkg::PULSE_MAX_RST;
            cfg_reg.pulse_min            <= tmm_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_centre         <= tmm_pkg::PULSE_CENTRE_RST;
            cfg_reg.alt_switch_level     <= tmm_pkg::ALT_LEVEL_RST;
            cfg_reg.heading_switch_level <= tmm_pkg::HEADING_LEVEL_RST;
            cfg_reg.throttle_zone        <= tmm_pkg::THROTTLE_ZONE_RST;
            cfg_reg.heading_gain         <= tmm_pkg::HEADING_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (tmm_pkg::cfg_index_t'(cfg_index))
                tmm_pkg::CFG_MIN_THROTTLE:  cfg_reg.min_throttle         <= cfg_data;
                tmm_pkg::CFG_PULSE_MAX:     cfg_reg.pulse_max            <= cfg_data;
                tmm_pkg::CFG_PULSE_MIN:     cfg_reg.pulse_min            <= cfg_data;
                tmm_pkg::CFG_PULSE_CENTRE:  cfg_reg.pulse_centre         <= cfg_data;
                tmm_pkg::CFG_ALT_LEVEL:     cfg_reg.alt_switch_level     <= cfg_data;
                tmm_pkg::CFG_HEADING_LEVEL: cfg_reg.heading_switch_level <= cfg_data;
                tmm_pkg::CFG_THROTTLE_ZONE: cfg_reg.throttle_zone        <= cfg_data;
                tmm_pkg::CFG_HEADING_GAIN:  cfg_reg.heading_gain         <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_en)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_en)
        begin
            in_word_reg <= tmm_pkg::in_word_t'(s_tdata);
        end
        if (hold_fire)
        begin
            mid_word_reg <= hold_word;
        end
        if (mid_valid_reg && out_en)
        begin
            out_word_reg <= mix_word;
        end
    end

    tmm_hold u_hold (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (hold_fire),
        .word  (in_word_reg),
        .cfg   (cfg_reg),
        .hold  (hold_word)
    );

    tmm_mix u_mix (
        .hold (mid_word_reg),
        .cfg  (cfg_reg),
        .word (mix_word)
    );

`ifndef ASSERT_OFF
    // Engaging hold passes the captured throttle through unchanged
    a_engage_capture: assert property (@(posedge clk) disable iff (!rst_n)
        hold_fire && hold_word.engage |=>
            mid_word_reg.thr == $past(in_word_reg.throttle_level))
        else $error("engage step did not pass the captured throttle");

    // An engage step always leaves hold active
    a_engage_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.alt_engage |-> out_word_reg.alt_active)
        else $error("engage step reported hold inactive");

    // Input stalls only when every stage is full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && mid_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- rtl/tmm_hold.sv -----
// Hold stage: altitude and heading hold latches, effective throttle and heading product.
// Holds the latch state registers. Depends on tmm_pkg.
`default_nettype none

module tmm_hold (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire tmm_pkg::in_word_t word,
    input  wire tmm_pkg::cfg_t     cfg,
    output tmm_pkg::hold_t         hold
);

    logic              alt_hold_reg;
    logic              alt_hold_next;
    logic [11:0]       held_throttle_reg;
    logic [11:0]       held_throttle_next;
    logic              head_hold_reg;
    logic              head_hold_next;
    logic signed [8:0] held_heading_reg;
    logic signed [8:0] held_heading_next;

    logic               sw_on;
    logic               engage;
    logic [11:0]        held_thr;
    logic signed [12:0] thr_diff;
    logic [12:0]        thr_mag;
    logic               drop;
    logic signed [13:0] thr_sum;
    logic [11:0]        thr_sat;
    logic               hsw_on;
    logic signed [8:0]  held_h;
    logic               centred;
    logic               level;
    logic               keep;
    logic signed [9:0]  err;
    logic signed [8:0]  gain_s;
    logic signed [18:0] prod;

    // Altitude hold latch and effective throttle
    always_comb
    begin
        sw_on    = word.alt_switch <= cfg.alt_switch_level;
        engage   = sw_on && !alt_hold_reg;
        held_thr = engage ? word.throttle_level : held_throttle_reg;
        thr_diff = signed'({1'b0, word.throttle_level}) - signed'({1'b0, held_thr});
        thr_mag  = thr_diff[12] ? 13'(-thr_diff) : 13'(thr_diff);
        drop     = thr_mag > {1'b0, cfg.throttle_zone};
        thr_sum  = signed'({2'b00, held_thr})
                 + (engage ? 14'sd0 : 14'(word.alt_correction));
        if (thr_sum < 14'sd0)
        begin
            thr_sat = 12'd0;
        end
        else if (thr_sum > 14'sd4095)
        begin
            thr_sat = 12'd4095;
        end
        else
        begin
            thr_sat = thr_sum[11:0];
        end
        alt_hold_next      = sw_on && !drop;
        held_throttle_next = held_thr;
    end

    // Heading hold latch and gain product
    always_comb
    begin
        hsw_on  = word.heading_switch <= cfg.heading_switch_level;
        held_h  = (hsw_on && !head_hold_reg) ? word.heading_deg : held_heading_reg;
        centred = (word.yaw_stick > -11'sd30) && (word.yaw_stick < 11'sd30);
        level   = (word.roll_deg > -9'sd25) && (word.roll_deg < 9'sd25)
               && (word.pitch_deg > -9'sd25) && (word.pitch_deg < 9'sd25);
        keep    = centred && hsw_on;
        err     = 10'(word.heading_deg) - 10'(held_h);
        gain_s  = signed'({1'b0, cfg.heading_gain});
        prod    = err * gain_s;
        head_hold_next    = hsw_on;
        held_heading_next = keep ? held_h : word.heading_deg;
    end

    // Assemble the stage result
    always_comb
    begin
        hold.thr         = sw_on ? thr_sat : word.throttle_level;
        hold.engage      = engage;
        hold.active      = alt_hold_next;
        hold.pitch_drive = word.pitch_drive;
        hold.roll_drive  = word.roll_drive;
        hold.yaw_drive   = word.yaw_drive;
        hold.yaw_stick   = word.yaw_stick;
        hold.head_prod   = (keep && level) ? prod : 19'sd0;
    end

    // Advance latch state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_hold_reg      <= 1'b0;
            held_throttle_reg <= 12'd0;
            head_hold_reg     <= 1'b0;
            held_heading_reg  <= 9'sd0;
        end
        else if (fire)
        begin
            alt_hold_reg      <= alt_hold_next;
            held_throttle_reg <= held_throttle_next;
            head_hold_reg     <= head_hold_next;
            held_heading_reg  <= held_heading_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tmm_mix.sv -----
// Mixer stage: motor mixing with pitch thirds, heading correction and servo clamp.
// Purely combinational. Depends on tmm_pkg.
`default_nettype none

module tmm_mix (
    input  wire tmm_pkg::hold_t  hold,
    input  wire tmm_pkg::cfg_t   cfg,
    output tmm_pkg::out_word_t   word
);

    // Truncating divide by 3 for |x| <= 8192, reciprocal 43691 / 2^17
    function automatic logic signed [12:0] div3(input logic signed [14:0] x);
        logic [13:0] mag;
        logic [29:0] prod;
        logic [11:0] q;
        mag  = x[14] ? 14'(-x) : x[13:0];
        prod = 30'(mag) * 30'(16'd43691);
        q    = prod[28:17];
        return x[14] ? -13'(q) : 13'(q);
    endfunction

    // Truncating divide by 30 for |x| < 2^17, reciprocal 139811 / 2^22
    function automatic logic signed [13:0] div30(input logic signed [18:0] x);
        logic [17:0] mag;
        logic [35:0] prod;
        logic [12:0] q;
        mag  = x[18] ? 18'(-x) : x[17:0];
        prod = 36'(mag) * 36'(18'd139811);
        q    = prod[34:22];
        return x[18] ? -14'(q) : 14'(q);
    endfunction

    // Lower bound tested first, so when they cross a value below lo gets lo and any other gets hi
    function automatic logic [11:0] clamp(input logic signed [15:0] v,
                                          input logic [11:0] lo,
                                          input logic [11:0] hi);
        logic [11:0] r;
        if (v < signed'({4'b0000, lo}))
        begin
            r = lo;
        end
        else if (v > signed'({4'b0000, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[11:0];
        end
        return r;
    endfunction

    logic signed [12:0] d2;
    logic signed [12:0] d4;
    logic signed [15:0] thr_s;
    logic signed [15:0] v_left;
    logic signed [15:0] v_right;
    logic signed [15:0] v_tail;
    logic signed [13:0] head_corr;
    logic signed [15:0] stick_eff;
    logic signed [15:0] v_servo;

    // Mix motors
    always_comb
    begin
        d2      = div3(15'(signed'({hold.pitch_drive, 1'b0})));
        d4      = div3(15'(signed'({hold.pitch_drive, 2'b00})));
        thr_s   = signed'({4'b0000, hold.thr});
        v_left  = thr_s + 16'(hold.roll_drive) - 16'(d2);
        v_right = thr_s - 16'(hold.roll_drive) - 16'(d2);
        v_tail  = thr_s + 16'(d4);
        if (hold.thr <= cfg.min_throttle)
        begin
            word.motor_left  = hold.thr;
            word.motor_right = hold.thr;
            word.motor_tail  = hold.thr;
        end
        else
        begin
            word.motor_left  = clamp(v_left, cfg.min_throttle, cfg.pulse_max);
            word.motor_right = clamp(v_right, cfg.min_throttle, cfg.pulse_max);
            word.motor_tail  = clamp(v_tail, cfg.min_throttle, cfg.pulse_max);
        end

        // Heading-corrected stick into the tail servo
        head_corr  = div30(hold.head_prod);
        stick_eff  = 16'(hold.yaw_stick) - 16'(head_corr);
        v_servo    = signed'({4'b0000, cfg.pulse_centre}) - stick_eff
                   + 16'(hold.yaw_drive);
        word.tail_servo = clamp(v_servo, cfg.pulse_min, cfg.pulse_max);
        word.alt_engage = hold.engage;
        word.alt_active = hold.active;
        word.pad        = 6'd0;
    end

endmodule

`default_nettype wire

// ----- sim/tb_tricopter_motor_mixer.sv -----
// Self-checking testbench for tricopter_motor_mixer: streams control updates under
// several register settings and idle patterns and checks every result word in order.
// Depends on tmm_pkg and the tricopter_motor_mixer RTL.

module tb_tricopter_motor_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import tmm_pkg::*;

    localparam int SW_OFF = 4095;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Control updates waiting to be offered, and result words owed by the block
    in_word_t  updates_pending[$];
    out_word_t motor_cmds_due[$];

    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  long_stall_go = 1'b0;
    logic rx_hold = 1'b0;

    // Mirror of the register file and of the hold latches
    cfg_t shadow_cfg = '{MIN_THROTTLE_RST, PULSE_MAX_RST, PULSE_MIN_RST, PULSE_CENTRE_RST,
                         ALT_LEVEL_RST, HEADING_LEVEL_RST, THROTTLE_ZONE_RST,
                         HEADING_GAIN_RST};
    bit alt_hold_on = 1'b0;
    int held_throttle = 0;
    bit heading_hold_on = 1'b0;
    int held_heading = 0;

    // Flight profile used to shape the random updates
    int cruise_thr = 1500;
    bit alt_sw_on = 1'b0;
    bit head_sw_on = 1'b0;

    tricopter_motor_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Lower bound tested first, so when they cross a value below lo gets lo and any other gets hi
    function automatic int bound(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the hold latches by one update and compute its motor and servo word
    function automatic out_word_t mix_update(in_word_t w);
        out_word_t r;
        int thr, corr, pitch, roll, yaw, stick, heading, roll_a, pitch_a;
        int lo, hi, m0, m1, m2, servo, err;
        bit engage;
        thr     = int'(w.throttle_level);
        corr    = int'(w.alt_correction);
        pitch   = int'(w.pitch_drive);
        roll    = int'(w.roll_drive);
        yaw     = int'(w.yaw_drive);
        stick   = int'(w.yaw_stick);
        heading = int'(w.heading_deg);
        roll_a  = int'(w.roll_deg);
        pitch_a = int'(w.pitch_deg);
        lo      = int'(shadow_cfg.min_throttle);
        hi      = int'(shadow_cfg.pulse_max);
        engage  = 1'b0;

        // Altitude hold: latch on the switch, drop outside the throttle zone
        if (w.alt_switch <= shadow_cfg.alt_switch_level)
        begin
            if (!alt_hold_on)
            begin
                alt_hold_on   = 1'b1;
                held_throttle = thr;
                engage        = 1'b1;
            end
        end
        else
            alt_hold_on = 1'b0;
        if (alt_hold_on)
        begin
            if (magnitude(thr - held_throttle) > int'(shadow_cfg.throttle_zone))
                alt_hold_on = 1'b0;
            thr = bound(held_throttle + (engage ? 0 : corr), 0, 4095);
        end

        // Motor mix
        if (thr <= lo)
        begin
            m0 = thr;
            m1 = thr;
            m2 = thr;
        end
        else
        begin
            m0 = bound(thr + roll - (pitch * 2) / 3, lo, hi);
            m1 = bound(thr - roll - (pitch * 2) / 3, lo, hi);
            m2 = bound(thr + (pitch * 4) / 3, lo, hi);
        end

        // Heading hold: correct yaw only while centered, held and level
        if (w.heading_switch <= shadow_cfg.heading_switch_level)
        begin
            if (!heading_hold_on)
            begin
                heading_hold_on = 1'b1;
                held_heading    = heading;
            end
        end
        else
            heading_hold_on = 1'b0;
        if (magnitude(stick) < 30 && heading_hold_on)
        begin
            err = heading - held_heading;
            if (magnitude(roll_a) < 25 && magnitude(pitch_a) < 25)
                stick = stick - (err * int'(shadow_cfg.heading_gain)) / 30;
        end
        else
            held_heading = heading;

        servo = bound(int'(shadow_cfg.pulse_centre) - stick + yaw,
                      int'(shadow_cfg.pulse_min), int'(shadow_cfg.pulse_max));

        r = '0;
        r.motor_left  = m0[11:0];
        r.motor_right = m1[11:0];
        r.motor_tail  = m2[11:0];
        r.tail_servo  = servo[11:0];
        r.alt_engage  = engage;
        r.alt_active  = alt_hold_on;
        return r;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Driver: record each accepted word, then offer the next one or idle
    always @(posedge clk)
    begin
        bit busy;
        in_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                w = s_tdata;
                motor_cmds_due.push_back(mix_update(w));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (updates_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= updates_pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result word, then pick the next ready
    always @(posedge clk)
    begin
        out_word_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (motor_cmds_due.size() == 0)
                begin
                    $error("result word with no update outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = motor_cmds_due.pop_front();
                    check_field("motor_left", want.motor_left, got.motor_left);
                    check_field("motor_right", want.motor_right, got.motor_right);
                    check_field("motor_tail", want.motor_tail, got.motor_tail);
                    check_field("tail_servo", want.tail_servo, got.tail_servo);
                    check_field("alt_engage", want.alt_engage, got.alt_engage);
                    check_field("alt_active", want.alt_active, got.alt_active);
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input
    initial
    begin : rx_holdoff
        wait (long_stall_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(cfg_index_t idx, logic [11:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MIN_THROTTLE:  shadow_cfg.min_throttle = val;
            CFG_PULSE_MAX:     shadow_cfg.pulse_max = val;
            CFG_PULSE_MIN:     shadow_cfg.pulse_min = val;
            CFG_PULSE_CENTRE:  shadow_cfg.pulse_centre = val;
            CFG_ALT_LEVEL:     shadow_cfg.alt_switch_level = val;
            CFG_HEADING_LEVEL: shadow_cfg.heading_switch_level = val;
            CFG_THROTTLE_ZONE: shadow_cfg.throttle_zone = val;
            CFG_HEADING_GAIN:  shadow_cfg.heading_gain = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(int mt, int pmx, int pmn, int pc, int al, int hl, int tz,
                                int hg);
        write_reg(CFG_MIN_THROTTLE, mt[11:0]);
        write_reg(CFG_PULSE_MAX, pmx[11:0]);
        write_reg(CFG_PULSE_MIN, pmn[11:0]);
        write_reg(CFG_PULSE_CENTRE, pc[11:0]);
        write_reg(CFG_ALT_LEVEL, al[11:0]);
        write_reg(CFG_HEADING_LEVEL, hl[11:0]);
        write_reg(CFG_THROTTLE_ZONE, tz[11:0]);
        write_reg(CFG_HEADING_GAIN, hg[11:0]);
    endtask

    task automatic apply_setting(int k);
        case (k)
            0: program_regs(1100, 2000, 1000, 1500, 1300, 1300, 50, 30);
            1: program_regs(0, 0, 0, 0, 0, 0, 0, 0);
            2: program_regs(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
            3: program_regs(1900, 1200, 1800, 1500, 1300, 1300, 80, 255);
            default:
                program_regs($urandom_range(1300, 900), $urandom_range(2100, 1700),
                             $urandom_range(1100, 900), $urandom_range(1600, 1400),
                             $urandom_range(1600, 1000), $urandom_range(1600, 1000),
                             $urandom_range(200, 0), $urandom_range(4095, 0));
        endcase
    endtask

    task automatic push_item(int thr, int alt_sw, int corr, int pitch, int roll, int yaw,
                             int stick, int head_sw, int heading, int roll_a, int pitch_a);
        in_word_t w;
        w = '0;
        w.throttle_level = thr[11:0];
        w.alt_switch     = alt_sw[11:0];
        w.alt_correction = corr[11:0];
        w.pitch_drive    = pitch[11:0];
        w.roll_drive     = roll[11:0];
        w.yaw_drive      = yaw[11:0];
        w.yaw_stick      = stick[10:0];
        w.heading_switch = head_sw[11:0];
        w.heading_deg    = heading[8:0];
        w.roll_deg       = roll_a[8:0];
        w.pitch_deg      = pitch_a[8:0];
        updates_pending.push_back(w);
    endtask

    function automatic int switch_value(bit on, logic [11:0] level);
        if (on)
            return $urandom_range(int'(level), 0);
        if (level == 12'hFFF)
            return SW_OFF;
        return $urandom_range(4095, int'(level) + 1);
    endfunction

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // Mostly a plausible flight with held switches and small drift; some pure noise
    task automatic queue_flight_update(bit noisy);
        int z;
        if (noisy)
            push_item(span(0, 4095), span(0, 4095), span(-2048, 2047), span(-2048, 2047),
                      span(-2048, 2047), span(-2048, 2047), span(-1024, 1023),
                      span(0, 4095), span(-180, 180), span(-180, 180), span(-180, 180));
        else
        begin
            if ($urandom_range(19) == 0)
                alt_sw_on = !alt_sw_on;
            if ($urandom_range(14) == 0)
                head_sw_on = !head_sw_on;
            z = int'(shadow_cfg.throttle_zone);
            if ($urandom_range(24) == 0)
                cruise_thr = span(0, 4095);
            else
                cruise_thr = bound(cruise_thr + span(-z - 5, z + 5), 0, 4095);
            push_item(cruise_thr, switch_value(alt_sw_on, shadow_cfg.alt_switch_level),
                      span(-200, 200), span(-300, 300), span(-300, 300), span(-300, 300),
                      span(-40, 40),
                      switch_value(head_sw_on, shadow_cfg.heading_switch_level),
                      span(-180, 180), span(-35, 35), span(-35, 35));
        end
    endtask

    // Hold until every offered word is accepted and every result has come back
    task automatic wait_quiet();
        while (updates_pending.size() != 0 || motor_cmds_due.size() != 0 || s_tvalid ||
               rx_hold)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and third-of-pitch truncation
        push_item(0, SW_OFF, 0, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(4095, SW_OFF, 2047, 2047, -2048, 2047, -1024, SW_OFF, 180, 180, 180);
        push_item(1500, SW_OFF, -2048, -2048, 2047, -2048, 1023, SW_OFF, -180, -180, -180);
        push_item(1500, SW_OFF, 0, -7, 5, 0, 0, SW_OFF, 0, 0, 0);
        push_item(1101, SW_OFF, 0, -1, 0, 0, 0, SW_OFF, 0, 0, 0);
        // Altitude hold: engage ignores correction, low saturation, zone exit
        push_item(1500, 1300, 500, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(1520, 0, 300, 30, 20, 10, 0, SW_OFF, 0, 0, 0);
        push_item(1480, 1000, -2048, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(1600, 1000, 100, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(4000, SW_OFF, 0, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        // Re-engage near the top and saturate high
        push_item(4000, 500, 0, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(4010, 500, 2047, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        push_item(2000, SW_OFF, 0, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        // Heading hold: engage, correct, tilted, pitched, stick off center
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 0, 10, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 1300, 40, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 1300, 60, 30, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 0, 60, 0, -25);
        push_item(1500, SW_OFF, 0, 0, 0, 0, -29, 0, 60, 24, -24);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 30, 0, 90, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 0, 90, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, SW_OFF, -180, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 0, -180, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, 0, 180, 0, 0);
        wait_quiet();

        // Crossed clamp bounds on motors and servo
        write_reg(CFG_MIN_THROTTLE, 12'd1900);
        write_reg(CFG_PULSE_MAX, 12'd1200);
        write_reg(CFG_PULSE_MIN, 12'd1800);
        push_item(1950, SW_OFF, 0, 0, 100, 0, 0, SW_OFF, 0, 0, 0);
        push_item(1500, SW_OFF, 0, 0, 0, 0, 0, SW_OFF, 0, 0, 0);
        wait_quiet();

        // Random phases, one register setting and idle pattern each
        for (k = 0; k < 10; k++)
        begin
            apply_setting(k);
            case (k % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            repeat (100) queue_flight_update($urandom_range(9) < 3);
            if (k == 4)
                long_stall_go = 1'b1;
            wait_quiet();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && motor_cmds_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
